// ----- rtl/core/lst_pkg.sv -----
// lst_pkg: item types, operation and status codes, sequencer states
// shared by every file of the indexed list store but lst_mem; no dependencies
package lst_pkg;

  localparam int IDX_W = 10;
  localparam int VAL_W = 32;
  localparam int TOT_W = 11;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_SET    = 3'd1,
    OP_GET    = 3'd2,
    OP_ERASE  = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT,
    S_FILL,
    S_GET_WAIT,
    S_RESULT
  } state_t;

  typedef struct packed {
    op_t              operation;
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] read_value;
    logic [TOT_W-1:0] entry_total;
    status_t          status;
  } out_item_t;

endpackage

// ----- rtl/core/lst_mem.sv -----
// lst_mem: element store, one write port and one registered read port
// no package dependencies
module lst_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/lst_seq.sv -----
// lst_seq: sequencer with one shared address step unit that moves entries
// through lst_mem for insert and erase; uses lst_pkg
module lst_seq #(
  parameter int LIST_DEPTH    = 1024,
  parameter int ELEMENT_WIDTH = 32,
  parameter int AW            = 10
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     item_valid,
  input  lst_pkg::in_item_t        item,
  output logic                     item_ready,
  output logic                     res_valid,
  output lst_pkg::out_item_t       res,
  input  logic                     res_take,
  output logic                     mem_we,
  output logic [AW-1:0]            mem_waddr,
  output logic [ELEMENT_WIDTH-1:0] mem_wdata,
  output logic                     mem_re,
  output logic [AW-1:0]            mem_raddr,
  input  logic [ELEMENT_WIDTH-1:0] mem_rdata
);
  import lst_pkg::*;

  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int MW = (CW > IDX_W) ? CW : IDX_W;

  state_t                   state_r, state_nxt;
  op_t                      op_r, op_nxt;
  logic [MW-1:0]            idx_r, idx_nxt;
  logic [ELEMENT_WIDTH-1:0] val_r, val_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic [AW-1:0]            ptr_r, ptr_nxt;
  logic [AW-1:0]            wa_r, wa_nxt;
  logic [AW-1:0]            end_r, end_nxt;
  logic [ELEMENT_WIDTH-1:0] rd_r, rd_nxt;
  status_t                  st_r, st_nxt;

  logic [MW-1:0] cnt_ext;
  logic [CW-1:0] cnt_m1;
  logic [AW-1:0] idx_a;
  logic [AW-1:0] step;
  logic          last;

  // shared step unit: next read address and end compare
  assign cnt_ext = MW'(cnt_r);
  assign cnt_m1  = cnt_r - CW'(1);
  assign idx_a   = AW'(idx_r);
  assign step    = ptr_r + ((op_r == OP_ERASE) ? AW'(1) : {AW{1'b1}});
  assign last    = (ptr_r == end_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    idx_r <= idx_nxt;
    val_r <= val_nxt;
    ptr_r <= ptr_nxt;
    wa_r  <= wa_nxt;
    end_r <= end_nxt;
    rd_r  <= rd_nxt;
    st_r  <= st_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    idx_nxt   = idx_r;
    val_nxt   = val_r;
    cnt_nxt   = cnt_r;
    ptr_nxt   = ptr_r;
    wa_nxt    = wa_r;
    end_nxt   = end_r;
    rd_nxt    = rd_r;
    st_nxt    = st_r;
    mem_we    = 1'b0;
    mem_waddr = wa_r;
    mem_wdata = val_r;
    mem_re    = 1'b0;
    mem_raddr = ptr_r;
    res_valid = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (item_valid) begin
          op_nxt    = item.operation;
          idx_nxt   = MW'(item.index);
          val_nxt   = ELEMENT_WIDTH'(item.value);
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        rd_nxt    = '0;
        st_nxt    = ST_OK;
        state_nxt = S_RESULT;
        unique case (op_r)
          OP_INSERT: begin
            if (idx_r > cnt_ext) begin
              st_nxt = ST_RANGE;
            end else if (cnt_r >= CW'(LIST_DEPTH)) begin
              st_nxt = ST_FULL;
            end else if (idx_r == cnt_ext) begin
              mem_we    = 1'b1;
              mem_waddr = idx_a;
              cnt_nxt   = cnt_r + CW'(1);
            end else begin
              mem_re    = 1'b1;
              mem_raddr = AW'(cnt_m1);
              ptr_nxt   = AW'(cnt_m1);
              wa_nxt    = AW'(cnt_r);
              end_nxt   = idx_a;
              state_nxt = S_SHIFT;
            end
          end
          OP_SET: begin
            if (idx_r >= cnt_ext) begin
              st_nxt = ST_RANGE;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = idx_a;
            end
          end
          OP_GET: begin
            if (idx_r >= cnt_ext) begin
              st_nxt = ST_RANGE;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = idx_a;
              state_nxt = S_GET_WAIT;
            end
          end
          OP_ERASE: begin
            if (idx_r >= cnt_ext) begin
              st_nxt = ST_RANGE;
            end else if (idx_r == MW'(cnt_m1)) begin
              cnt_nxt = cnt_m1;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = idx_a + AW'(1);
              ptr_nxt   = idx_a + AW'(1);
              wa_nxt    = idx_a;
              end_nxt   = AW'(cnt_m1);
              state_nxt = S_SHIFT;
            end
          end
          OP_CLEAR: begin
            cnt_nxt = '0;
          end
          default: begin
          end
        endcase
      end
      S_SHIFT: begin
        // write the word read last cycle one place over, read the next
        mem_we    = 1'b1;
        mem_waddr = wa_r;
        mem_wdata = mem_rdata;
        wa_nxt    = ptr_r;
        if (last) begin
          if (op_r == OP_INSERT) begin
            state_nxt = S_FILL;
          end else begin
            cnt_nxt   = cnt_m1;
            state_nxt = S_RESULT;
          end
        end else begin
          mem_re    = 1'b1;
          mem_raddr = step;
          ptr_nxt   = step;
        end
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = end_r;
        cnt_nxt   = cnt_r + CW'(1);
        state_nxt = S_RESULT;
      end
      S_GET_WAIT: begin
        rd_nxt    = mem_rdata;
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign item_ready      = (state_r == S_IDLE);
  assign res.read_value  = VAL_W'(rd_r);
  assign res.entry_total = TOT_W'(cnt_r);
  assign res.status      = st_r;

endmodule

// ----- rtl/core/indexed_list_store.sv -----
// indexed_list_store: top level with sequencer, element store and output register
// depends on lst_pkg, lst_mem and lst_seq
//
// An ordered list of element words with insert, set, get, erase and clear.
// Input channel in_valid / in_stall / in_item carries one operation per item;
// the result channel out_valid / out_stall / out_item returns exactly one
// result per item: read value, entry count after the operation and status.
// One item is worked on at a time; in_stall is high from acceptance until
// the result is handed to the output register.
// Insert and erase at index i shift the entries behind index i one place,
// the memory write port moving one entry per cycle.
// The output register lets the next item be accepted while a result still
// waits under out_stall; that item then holds its result until the register
// frees up. Reset empties the list and drops any pending result; the
// element store itself is not cleared.
module indexed_list_store #(
  parameter int LIST_DEPTH    = 1024,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lst_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output lst_pkg::out_item_t out_item
);
  import lst_pkg::*;

  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  logic                     item_ready;
  logic                     res_valid;
  out_item_t                res;
  logic                     res_take;
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic [ELEMENT_WIDTH-1:0] mem_wdata;
  logic                     mem_re;
  logic [AW-1:0]            mem_raddr;
  logic [ELEMENT_WIDTH-1:0] mem_rdata;
  logic                     out_valid_r;
  out_item_t                out_item_r;

  lst_seq #(
    .LIST_DEPTH   (LIST_DEPTH),
    .ELEMENT_WIDTH(ELEMENT_WIDTH),
    .AW           (AW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_valid(in_valid),
    .item      (in_item),
    .item_ready(item_ready),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  lst_mem #(
    .DEPTH(LIST_DEPTH),
    .WIDTH(ELEMENT_WIDTH),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_item_r <= res;
    end
  end

  assign in_stall  = !item_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ----- rtl/core/lst_chk.sv -----
// lst_chk: port-level assertions for indexed_list_store, bound to the top
// depends on lst_pkg
module lst_chk #(
  parameter int LIST_DEPTH = 1024
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input lst_pkg::out_item_t out_item
);
  import lst_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted while another is in progress");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != ST_OK |-> out_item.read_value == '0)
    else $error("error result carries a read value");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == ST_FULL |-> out_item.entry_total == TOT_W'(LIST_DEPTH))
    else $error("full status with list not at capacity");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> int'(out_item.entry_total) <= LIST_DEPTH)
    else $error("entry count above capacity");

endmodule

bind indexed_list_store lst_chk #(.LIST_DEPTH(LIST_DEPTH)) u_lst_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_item (out_item)
);

// ----- test/indexed_list_store_test.sv -----
`timescale 1ns / 1ps
// indexed_list_store_test: self-checking bench for the indexed list store, with a shadow
// list predicting every result; directed, no-idle and random tests with random idling
// depends on lst_pkg and indexed_list_store
module indexed_list_store_test;
  import lst_pkg::*;

  localparam int LIST_DEPTH = 1024;
  localparam int IDX_MAX = (1 << IDX_W) - 1;
  localparam int STALL_LIMIT = 6 * (LIST_DEPTH + 8);
  localparam op_t OP_UNDEF_FIRST = op_t'(3'd5);
  localparam op_t OP_UNDEF_LAST = op_t'(3'd7);

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;

  logic [VAL_W-1:0] list_words [LIST_DEPTH];
  int unsigned list_len = 0;
  out_item_t queued_results [$];
  bit quiet = 1'b0;
  int unsigned fails = 0;
  int unsigned idle_cycles = 0;

  indexed_list_store #(
    .LIST_DEPTH(LIST_DEPTH),
    .ELEMENT_WIDTH(VAL_W)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic out_item_t apply_to_list(in_item_t it);
    out_item_t r;
    int unsigned pos;
    r = '0;
    pos = it.index;
    case (it.operation)
      OP_INSERT: begin
        if (pos > list_len) begin
          r.status = ST_RANGE;
        end else if (list_len >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (int unsigned k = list_len; k > pos; k--) list_words[k] = list_words[k-1];
          list_words[pos] = it.value;
          list_len++;
        end
      end
      OP_SET: begin
        if (pos >= list_len) r.status = ST_RANGE;
        else list_words[pos] = it.value;
      end
      OP_GET: begin
        if (pos >= list_len) r.status = ST_RANGE;
        else r.read_value = list_words[pos];
      end
      OP_ERASE: begin
        if (pos >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          for (int unsigned k = pos; k + 1 < list_len; k++) list_words[k] = list_words[k+1];
          list_len--;
        end
      end
      OP_CLEAR: list_len = 0;
      default: ;
    endcase
    r.entry_total = TOT_W'(list_len);
    return r;
  endfunction

  task automatic send_op(input op_t op, input int unsigned idx, input logic [VAL_W-1:0] val);
    in_item_t it;
    logic stalled;
    it.operation = op;
    it.index = IDX_W'(idx);
    it.value = val;
    while (!quiet && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    queued_results.push_back(apply_to_list(it));
  endtask

  task automatic drain_results;
    in_valid <= 1'b0;
    while (queued_results.size() != 0) @(posedge clk);
  endtask

  // range errors and ignored codes on an empty list
  task automatic test_empty_list;
    send_op(OP_GET, 0, '0);
    send_op(OP_SET, 0, '1);
    send_op(OP_ERASE, 0, '0);
    send_op(OP_INSERT, 1, '1);
    send_op(OP_INSERT, IDX_MAX, '1);
    send_op(OP_UNDEF_FIRST, 0, '1);
    send_op(OP_CLEAR, IDX_MAX, '1);
  endtask

  task automatic test_basic_edits;
    send_op(OP_INSERT, 0, '0);
    send_op(OP_INSERT, 1, '1);
    send_op(OP_INSERT, 1, 32'h5a5a_a5a5);
    send_op(OP_INSERT, 0, 32'h0123_4567);
    send_op(OP_INSERT, 5, 32'h89ab_cdef);
    for (int unsigned k = 0; k < 4; k++) send_op(OP_GET, k, '0);
    send_op(OP_SET, 2, 32'hdead_beef);
    send_op(OP_GET, 2, '0);
    send_op(OP_GET, 4, '0);
    send_op(OP_ERASE, 1, '0);
    send_op(OP_ERASE, 2, '0);
    send_op(OP_GET, 1, '0);
    send_op(OP_UNDEF_LAST, 1, '1);
    send_op(OP_CLEAR, 0, '0);
    send_op(OP_GET, 0, '0);
  endtask

  task automatic test_random_ops(input int unsigned items, input int unsigned cap,
                                 input int unsigned grow_pct, input int unsigned clear_pct);
    op_t op;
    int unsigned idx;
    int unsigned roll;
    int unsigned pick;
    int unsigned top;
    for (int unsigned n = 0; n < items; n++) begin
      if (n == items / 2) drain_results();
      roll = $urandom_range(99);
      pick = $urandom_range(99);
      top = (list_len > IDX_MAX) ? IDX_MAX : list_len;
      if (roll < clear_pct) begin
        op = OP_CLEAR;
        idx = $urandom_range(IDX_MAX);
      end else if (roll < clear_pct + 6) begin
        // noise: any operation at any index
        op = op_t'($urandom_range(4));
        idx = $urandom_range(IDX_MAX);
      end else if (list_len == 0 || (list_len < cap && roll < grow_pct)) begin
        op = OP_INSERT;
        if (pick < 5) idx = $urandom_range(IDX_MAX);
        else if (pick < 20) idx = top;
        else idx = $urandom_range(top);
      end else begin
        case ($urandom_range(2))
          0: op = OP_SET;
          1: op = OP_GET;
          default: op = OP_ERASE;
        endcase
        if (pick < 8) idx = $urandom_range(IDX_MAX);
        else if (pick < 18) idx = list_len - 1;
        else if (pick < 24) idx = 0;
        else idx = $urandom_range(list_len - 1);
      end
      send_op(op, idx, $urandom());
    end
  endtask

  // a long stretch with no idling on either side
  task automatic test_no_idle;
    quiet = 1'b1;
    test_random_ops(100, LIST_DEPTH + 1, 60, 0);
    quiet = 1'b0;
  endtask

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 17);
  end

  always @(negedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (queued_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_item);
        fails++;
      end else begin
        want = queued_results.pop_front();
        if (out_item.read_value !== want.read_value) begin
          $display("%0t: read_value expected %h actual %h", $time, want.read_value,
                   out_item.read_value);
          fails++;
        end
        if (out_item.entry_total !== want.entry_total) begin
          $display("%0t: entry_total expected %0d actual %0d", $time, want.entry_total,
                   out_item.entry_total);
          fails++;
        end
        if (out_item.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   out_item.status);
          fails++;
        end
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL indexed_list_store");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_list();
    test_basic_edits();
    test_no_idle();
    test_random_ops(120, LIST_DEPTH + 1, 45, 0);
    test_random_ops(340, 40, 40, 3);
    drain_results();
    repeat (16) @(posedge clk);
    if (fails == 0) $display("PASS indexed_list_store");
    else $display("FAIL indexed_list_store");
    $finish;
  end

endmodule
